// ----- src/pva_pkg.sv -----
// Shared types, constants and the pitch table for the voice allocator.
package pva_pkg;

  localparam int unsigned VIDX_W  = 4;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned ENV_W   = 15;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned INC_W   = 32;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [ENV_W-1:0] ENV_MAX = 15'd32767;

  // Sample rate of the oscillator that uses the increments. It must be a power of two.
  localparam int unsigned AUDIO_RATE      = 16384;
  localparam int unsigned AUDIO_RATE_LOG2 = $clog2(AUDIO_RATE);
  // The table holds Q12 frequencies, and the increment carries 32 fraction bits.
  localparam int unsigned ROM_SHIFT       = 12 + AUDIO_RATE_LOG2;

  localparam logic [ENV_W-1:0]   ATTACK_RESET  = 15'd64;
  localparam logic [ENV_W-1:0]   RELEASE_RESET = 15'd64;
  localparam logic [SHIFT_W-1:0] GLIDE_RESET   = 5'd4;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_ATTACK  = 2'd0,
    ST_SUSTAIN = 2'd1,
    ST_RELEASE = 2'd2,
    ST_IDLE    = 2'd3
  } stage_e;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_GLIDE   = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_TICK
  } state_e;

  // One entry of the voice memory.
  typedef struct packed {
    logic              active;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [INC_W-1:0]  cur_inc;
    logic [INC_W-1:0]  tgt_inc;
    logic [ENV_W-1:0]  env;
    stage_e            stage;
    logic [AGE_W-1:0]  age;
  } voice_t;

  localparam voice_t VOICE_RESET = '{
    active:   1'b0,
    note:     '0,
    velocity: '0,
    cur_inc:  '0,
    tgt_inc:  '0,
    env:      '0,
    stage:    ST_IDLE,
    age:      '0
  };

  // Q12 frequencies of the top octave, notes 120 to 131.
  localparam logic [25:0] TOP_Q12 [12] = '{
    26'd34291786, 26'd36330882, 26'd38491228, 26'd40780036,
    26'd43204943, 26'd45774043, 26'd48495909, 26'd51379626,
    26'd54434817, 26'd57671680, 26'd61101017, 26'd64734272
  };

  // Equal-tempered phase increment of a note; lower octaves shift the top octave down.
  function automatic logic [INC_W-1:0] note_increment(input logic [NOTE_W-1:0] n);
    logic [3:0]  oct;
    logic [6:0]  semi;
    logic [5:0]  sh;
    logic [63:0] wide;
    oct = '0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= 7'(12 * k)) oct = 4'(k);
    end
    semi = n - ({3'b000, oct} << 3) - ({3'b000, oct} << 2);
    sh   = 6'(ROM_SHIFT) + 6'(4'd10 - oct);
    wide = {6'b0, TOP_Q12[semi[3:0]], 32'b0} >> sh;
    if (|wide[63:32]) begin
      return '1;
    end
    return wide[31:0];
  endfunction

endpackage

// ----- src/pva_state_mem.sv -----
// Voice state memory with one read and one write port and per-entry valid bits.
module pva_state_mem import pva_pkg::*; #(
  parameter int unsigned NUM_VOICES = 8,
  parameter int unsigned IdxW       = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output voice_t          rdata_o,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  voice_t          wdata_i
);

  voice_t                  mem_q [NUM_VOICES];
  logic [NUM_VOICES-1:0]   valid_q;
  voice_t                  rd_q;
  logic                    rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // An entry that was never written reads as the reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_ok_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_ok_q ? rd_q : VOICE_RESET;

endmodule

// ----- src/pva_voice_upd.sv -----
// Per-tick update of one voice: envelope stage step and glide of the pitch increment.
module pva_voice_upd import pva_pkg::*; (
  input  voice_t             voice_i,
  input  logic [ENV_W-1:0]   attack_step_i,
  input  logic [ENV_W-1:0]   release_step_i,
  input  logic [SHIFT_W-1:0] glide_shift_i,
  output voice_t             voice_o
);

  logic [ENV_W:0]   att_sum;
  logic [INC_W-1:0] diff;
  logic [INC_W-1:0] step;

  assign att_sum = {1'b0, voice_i.env} + {1'b0, attack_step_i};
  assign diff    = voice_i.tgt_inc - voice_i.cur_inc;
  assign step    = INC_W'($signed(diff) >>> glide_shift_i);

  always_comb begin
    voice_o         = voice_i;
    voice_o.cur_inc = voice_i.cur_inc + step;
    case (voice_i.stage)
      ST_ATTACK: begin
        if (att_sum >= {1'b0, ENV_MAX}) begin
          voice_o.env   = ENV_MAX;
          voice_o.stage = ST_SUSTAIN;
        end else begin
          voice_o.env = att_sum[ENV_W-1:0];
        end
      end
      ST_RELEASE: begin
        if (voice_i.env <= release_step_i) begin
          voice_o.env    = '0;
          voice_o.stage  = ST_IDLE;
          voice_o.active = 1'b0;
        end else begin
          voice_o.env = voice_i.env - release_step_i;
        end
      end
      default: begin
        voice_o.env = voice_i.env;
      end
    endcase
  end

endmodule

// ----- src/poly_voice_allocator_envelope_top.sv -----
// Top level of the polyphonic voice allocator with attack/release envelope and glide.
//
// The block keeps NUM_VOICES synth voices in one state memory with a single read port
// and a single write port, and serves one stream transaction at a time. A note-on scans
// every voice, one per cycle, for the lowest-index inactive voice and the voice with the
// smallest age, then loads the chosen voice with the note, the velocity, the pitch
// increment from the equal-tempered table and a fresh age, and starts its attack. A
// note-off scans for the first active voice with that note and puts it into release; if
// none matches, one all-zero result with tlast set comes out. A tick reads, steps and
// writes back every voice in index order and reports each one, with tlast on the final
// voice. Operation code 3 is taken and dropped without a result. Throughput is set by
// the memory's one read port, which sees one voice per cycle while the result side
// does not stall a tick. Results leave through an output register. No clearing pass
// follows reset: valid bits make every never-written voice read as idle with all
// other fields zero. The configuration registers are to be written only while the
// block is idle.
module poly_voice_allocator_envelope_top import pva_pkg::*; #(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream. tdata: note [6:0], velocity [13:7], zero fill [15:14].
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,
  // tuser: operation [1:0].
  input  logic [OP_W-1:0]   s_axis_tuser,
  // Result stream. tdata: voice_index [3:0], is_active [4], voice_note [11:5],
  // voice_velocity [18:12], envelope_level [33:19], env_stage [35:34],
  // pitch_increment [67:36], zero fill [71:68].
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [71:0]       m_axis_tdata,
  // tuser: stolen [0], found [1].
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_VOICES - 1);

  // Configuration registers.
  logic [ENV_W-1:0]   attack_q;
  logic [ENV_W-1:0]   release_q;
  logic [SHIFT_W-1:0] shift_q;
  logic               cfg_we;
  reg_e               cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_reg = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RESET;
      release_q <= RELEASE_RESET;
      shift_q   <= GLIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_ATTACK:  attack_q  <= pwdata[ENV_W-1:0];
        REG_RELEASE: release_q <= pwdata[ENV_W-1:0];
        REG_GLIDE:   shift_q   <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_ATTACK:  prdata = DATA_W'(attack_q);
      REG_RELEASE: prdata = DATA_W'(release_q);
      REG_GLIDE:   prdata = DATA_W'(shift_q);
      default:     prdata = '0;
    endcase
  end

  // Control and item registers.
  state_e              state_q, state_d;
  op_e                 op_q;
  logic [NOTE_W-1:0]   note_q;
  logic [VEL_W-1:0]    vel_q;
  logic [INC_W-1:0]    inc_q;
  logic [IdxW-1:0]     idx_q;
  logic [AGE_W-1:0]    age_q;

  // Scan results.
  logic                free_found_q;
  logic [IdxW-1:0]     free_idx_q;
  logic [IdxW-1:0]     min_idx_q;
  logic [AGE_W-1:0]    min_age_q;
  logic                match_q;
  logic [IdxW-1:0]     match_idx_q;
  voice_t              match_word_q;

  // Output register.
  logic                out_valid_q;
  logic [IdxW-1:0]     out_idx_q;
  voice_t              out_voice_q;
  logic                out_stolen_q;
  logic                out_found_q;
  logic                out_last_q;

  logic                in_accept;
  logic                is_last;
  logic                can_load;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  voice_t              mem_rdata;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  voice_t              mem_wdata;
  voice_t              ticked;
  logic                load;
  logic [IdxW-1:0]     load_idx;
  voice_t              load_voice;
  logic                load_stolen;
  logic                load_found;
  logic                load_last;
  logic [IdxW-1:0]     pick;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_last       = (idx_q == LastIdx);
  assign can_load      = !out_valid_q || m_axis_tready;
  assign pick          = free_found_q ? free_idx_q : min_idx_q;

  pva_state_mem #(
    .NUM_VOICES (NUM_VOICES),
    .IdxW       (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  pva_voice_upd u_upd (
    .voice_i        (mem_rdata),
    .attack_step_i  (attack_q),
    .release_step_i (release_q),
    .glide_shift_i  (shift_q),
    .voice_o        (ticked)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            OP_NOTE_ON, OP_NOTE_OFF: state_d = S_SCAN;
            OP_TICK:                 state_d = S_TICK;
            default:                 state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (is_last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (can_load) state_d = S_IDLE;
      end
      S_TICK: begin
        if (can_load && is_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory accesses and result loads. Reads run one entry ahead of the entry being
  // processed, and a tick writes entry idx while reading idx + 1, so a read never meets
  // a write to the same entry; a new item starts only after the last write has landed.
  always_comb begin
    mem_re      = 1'b0;
    mem_raddr   = IdxW'(idx_q + 1'b1);
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = ticked;
    load        = 1'b0;
    load_idx    = idx_q;
    load_voice  = ticked;
    load_stolen = 1'b0;
    load_found  = 1'b0;
    load_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        // An ignored code also reads entry 0; nothing uses that data.
        mem_raddr = '0;
        mem_re    = in_accept;
      end
      S_SCAN: begin
        mem_re = !is_last;
      end
      S_COMMIT: begin
        load = can_load;
        if (op_q == OP_NOTE_ON) begin
          mem_we             = can_load;
          mem_waddr          = pick;
          mem_wdata          = VOICE_RESET;
          mem_wdata.active   = 1'b1;
          mem_wdata.note     = note_q;
          mem_wdata.velocity = vel_q;
          mem_wdata.cur_inc  = inc_q;
          mem_wdata.tgt_inc  = inc_q;
          mem_wdata.env      = '0;
          mem_wdata.stage    = ST_ATTACK;
          mem_wdata.age      = age_q + 1'b1;
          load_idx           = pick;
          load_voice         = mem_wdata;
          load_stolen        = !free_found_q;
        end else if (match_q) begin
          mem_we           = can_load;
          mem_waddr        = match_idx_q;
          mem_wdata        = match_word_q;
          mem_wdata.stage  = ST_RELEASE;
          load_idx         = match_idx_q;
          load_voice       = mem_wdata;
          load_found       = 1'b1;
        end else begin
          // Unmatched note-off reports an all-zero result.
          load_idx   = '0;
          load_voice = '0;
        end
      end
      S_TICK: begin
        mem_we    = can_load;
        mem_re    = can_load && !is_last;
        load      = can_load;
        load_last = is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      age_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        idx_q <= '0;
      end else if ((state_q == S_SCAN) && !is_last) begin
        idx_q <= IdxW'(idx_q + 1'b1);
      end else if ((state_q == S_TICK) && can_load && !is_last) begin
        idx_q <= IdxW'(idx_q + 1'b1);
      end
      if ((state_q == S_COMMIT) && can_load && (op_q == OP_NOTE_ON)) begin
        age_q <= age_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, scan bookkeeping and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q         <= op_e'(s_axis_tuser);
      note_q       <= s_axis_tdata[6:0];
      vel_q        <= s_axis_tdata[13:7];
      inc_q        <= note_increment(s_axis_tdata[6:0]);
      free_found_q <= 1'b0;
      match_q      <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      if (!mem_rdata.active && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
      if ((idx_q == '0) || (mem_rdata.age < min_age_q)) begin
        min_age_q <= mem_rdata.age;
        min_idx_q <= idx_q;
      end
      if (mem_rdata.active && (mem_rdata.note == note_q) && !match_q) begin
        match_q      <= 1'b1;
        match_idx_q  <= idx_q;
        match_word_q <= mem_rdata;
      end
    end
    if (load) begin
      out_idx_q    <= load_idx;
      out_voice_q  <= load_voice;
      out_stolen_q <= load_stolen;
      out_found_q  <= load_found;
      out_last_q   <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_found_q, out_stolen_q};
  assign m_axis_tdata  = {4'b0000, out_voice_q.cur_inc, out_voice_q.stage, out_voice_q.env,
                          out_voice_q.velocity, out_voice_q.note, out_voice_q.active,
                          VIDX_W'(out_idx_q)};

`ifndef SYNTH
  // The state memory is written only while an item is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE))
    else $error("state memory written while idle");

  // A tick never writes the entry that it reads in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same voice entry in one cycle");

  // A result is loaded only when the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while stalled");

  // The age counter moves only when a note-on commits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(age_q) |-> $past((state_q == S_COMMIT) && (op_q == OP_NOTE_ON)))
    else $error("age counter changed outside a note-on commit");
`endif

endmodule

// ----- tb/sv/poly_voice_allocator_envelope_top_tb.sv -----
// Self-checking testbench for the polyphonic voice allocator with envelope and glide.
`timescale 1ns / 1ps

module poly_voice_allocator_envelope_top_tb;
  import pva_pkg::*;

  localparam int unsigned NV           = 8;
  // Cycles to let pass once the last expected result is in, so that an
  // ignored code or a note scan still in flight has surely finished.
  localparam int unsigned DRAIN_CYCLES = NV + 16;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned HOLD_CYCLES  = 200;
  // Operation code that the block takes and drops without a result.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  // Q12 frequencies of the highest octave (C9 to B9); lower octaves divide these down.
  localparam longint unsigned TOP_OCTAVE_Q12 [12] = '{
    64'd34291786, 64'd36330882, 64'd38491228, 64'd40780036,
    64'd43204943, 64'd45774043, 64'd48495909, 64'd51379626,
    64'd54434817, 64'd57671680, 64'd61101017, 64'd64734272
  };

  // One reported voice, in the order of the result fields.
  typedef struct packed {
    logic [3:0]  idx;
    logic        act;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [14:0] env;
    stage_e      stage;
    logic [31:0] inc;
    logic        stolen;
    logic        found;
    logic        last;
  } voice_report_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;
  logic [OP_W-1:0]   s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [71:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow copy of the configuration registers, updated as each write completes.
  logic [ENV_W-1:0]   attack_step_cfg  = ATTACK_RESET;
  logic [ENV_W-1:0]   release_step_cfg = RELEASE_RESET;
  logic [SHIFT_W-1:0] glide_shift_cfg  = GLIDE_RESET;

  // Predicted voice pool.
  bit          v_active [NV] = '{default: 1'b0};
  logic [6:0]  v_note   [NV] = '{default: '0};
  logic [6:0]  v_vel    [NV] = '{default: '0};
  logic [31:0] v_cur    [NV] = '{default: '0};
  logic [31:0] v_tgt    [NV] = '{default: '0};
  logic [14:0] v_env    [NV] = '{default: '0};
  stage_e      v_stage  [NV] = '{default: ST_IDLE};
  logic [31:0] v_age    [NV] = '{default: '0};
  logic [31:0] age_count     = '0;

  // Voice reports still owed by the block, oldest first.
  voice_report_t reports_due [$];

  // Run statistics and failure counters.
  int unsigned items_taken     = 0;
  int unsigned reports_checked = 0;
  int unsigned steals          = 0;
  int unsigned offs_missed     = 0;
  int unsigned ignored_codes   = 0;
  int unsigned settings_used   = 0;
  int unsigned mismatches      = 0;

  // Idling control: quiet turns off random gaps on both sides; a hold request
  // makes the receiver drop tready for one unbroken hold-off set by HOLD_CYCLES.
  bit          quiet         = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  poly_voice_allocator_envelope_top #(
    .NUM_VOICES(NV)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Equal-tempered phase increment: the top-octave frequency scaled by 2^32 and
  // divided by the sample rate, with one more halving for every octave down.
  function automatic logic [31:0] pitch_step(logic [6:0] note);
    int unsigned     octave;
    int unsigned     semitone;
    longint unsigned denom;
    longint unsigned wide;
    octave   = note / 12;
    semitone = note % 12;
    denom    = (64'(AUDIO_RATE) << 12) << (10 - octave);
    wide     = (TOP_OCTAVE_Q12[semitone] << 32) / denom;
    if (wide > 64'hFFFF_FFFF) begin
      wide = 64'hFFFF_FFFF;
    end
    return wide[31:0];
  endfunction

  function automatic voice_report_t voice_snapshot(int v, bit stolen, bit found, bit last);
    voice_report_t r;
    r.idx    = 4'(v);
    r.act    = v_active[v];
    r.note   = v_note[v];
    r.vel    = v_vel[v];
    r.env    = v_env[v];
    r.stage  = v_stage[v];
    r.inc    = v_cur[v];
    r.stolen = stolen;
    r.found  = found;
    r.last   = last;
    return r;
  endfunction

  // Applies one accepted input transaction to the predicted pool and queues the
  // reports it must produce.
  function automatic void step_voice_pool(logic [1:0] op, logic [6:0] note, logic [6:0] vel);
    int                 pick;
    bit                 stole;
    logic [31:0]        diff;
    logic signed [31:0] glide_delta;
    voice_report_t      miss;
    pick  = -1;
    stole = 1'b0;
    case (op)
      OP_NOTE_ON: begin
        for (int v = 0; v < NV; v++) begin
          if (!v_active[v] && pick < 0) pick = v;
        end
        // A full pool gives up the voice with the smallest age stamp, lowest index on a tie.
        if (pick < 0) begin
          stole = 1'b1;
          steals++;
          pick = 0;
          for (int v = 1; v < NV; v++) begin
            if (v_age[v] < v_age[pick]) pick = v;
          end
        end
        v_active[pick] = 1'b1;
        v_note[pick]   = note;
        v_vel[pick]    = vel;
        v_tgt[pick]    = pitch_step(note);
        v_cur[pick]    = v_tgt[pick];
        v_env[pick]    = '0;
        v_stage[pick]  = ST_ATTACK;
        age_count      = age_count + 32'd1;
        v_age[pick]    = age_count;
        reports_due.push_back(voice_snapshot(pick, stole, 1'b0, 1'b1));
      end
      OP_NOTE_OFF: begin
        for (int v = 0; v < NV; v++) begin
          if (v_active[v] && v_note[v] == note && pick < 0) pick = v;
        end
        if (pick < 0) begin
          offs_missed++;
          miss      = '0;
          miss.last = 1'b1;
          reports_due.push_back(miss);
        end else begin
          v_stage[pick] = ST_RELEASE;
          reports_due.push_back(voice_snapshot(pick, 1'b0, 1'b1, 1'b1));
        end
      end
      OP_TICK: begin
        for (int v = 0; v < NV; v++) begin
          if (v_stage[v] == ST_ATTACK) begin
            if (32'(v_env[v]) + 32'(attack_step_cfg) >= 32'(ENV_MAX)) begin
              v_env[v]   = ENV_MAX;
              v_stage[v] = ST_SUSTAIN;
            end else begin
              v_env[v] = v_env[v] + attack_step_cfg;
            end
          end else if (v_stage[v] == ST_RELEASE) begin
            if (v_env[v] <= release_step_cfg) begin
              v_env[v]    = '0;
              v_stage[v]  = ST_IDLE;
              v_active[v] = 1'b0;
            end else begin
              v_env[v] = v_env[v] - release_step_cfg;
            end
          end
          // Glide moves by the signed difference shifted right arithmetically.
          diff        = v_tgt[v] - v_cur[v];
          glide_delta = diff;
          glide_delta = glide_delta >>> glide_shift_cfg;
          v_cur[v]    = v_cur[v] + glide_delta;
        end
        for (int v = 0; v < NV; v++) begin
          reports_due.push_back(voice_snapshot(v, 1'b0, 1'b0, v == NV - 1));
        end
      end
      default: ignored_codes++;
    endcase
  endfunction

  function automatic string show_report(voice_report_t r);
    return $sformatf("voice %0d act %0b note %0d vel %0d env %0d stage %s inc %h st %0b fd %0b lt %0b",
                     r.idx, r.act, r.note, r.vel, r.env, r.stage.name(), r.inc,
                     r.stolen, r.found, r.last);
  endfunction

  // The monitor samples both streams at the rising edge, where the block
  // samples them too. Result transactions are checked against the oldest
  // expectation first; then an accepted input transaction is predicted. No
  // result of an input can leave at the edge that accepts it, so this order
  // never pairs a result with the wrong expectation.
  always @(posedge clk_i) begin : monitor
    voice_report_t got;
    voice_report_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx    = m_axis_tdata[3:0];
        got.act    = m_axis_tdata[4];
        got.note   = m_axis_tdata[11:5];
        got.vel    = m_axis_tdata[18:12];
        got.env    = m_axis_tdata[33:19];
        got.stage  = stage_e'(m_axis_tdata[35:34]);
        got.inc    = m_axis_tdata[67:36];
        got.stolen = m_axis_tuser[0];
        got.found  = m_axis_tuser[1];
        got.last   = m_axis_tlast;
        reports_checked++;
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result: %s", $realtime, show_report(got));
          end
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s", show_report(want));
              $display("  actual   %s", show_report(got));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        step_voice_pool(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[13:7]);
      end
    end
  end

  // Receiver: random backpressure, none while quiet, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 31);
    end
  end

  // Offers one input transaction, after a random gap unless quiet, and returns
  // at the edge that accepts it. tvalid stays high so that a following call can
  // offer the next item back to back without a second assignment in one step.
  task automatic send_item(logic [1:0] op, logic [6:0] note, logic [6:0] vel);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, vel, note};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering, waits for every owed result and lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One configuration write: setup cycle, then access until pready.
  task automatic write_register(reg_e r, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({r, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_ATTACK:  attack_step_cfg  = value[ENV_W-1:0];
      REG_RELEASE: release_step_cfg = value[ENV_W-1:0];
      REG_GLIDE:   glide_shift_cfg  = value[SHIFT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned attack, int unsigned release_amt, int unsigned shift);
    write_register(REG_ATTACK, DATA_W'(attack));
    write_register(REG_RELEASE, DATA_W'(release_amt));
    write_register(REG_GLIDE, DATA_W'(shift));
    settings_used++;
  endtask

  // Envelope step for a random phase: mostly mid values so voices move through
  // all stages in a few ticks, sometimes an extreme or any value at all.
  function automatic int unsigned random_env_step();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return 32767;
    if (pick == 2) return $urandom_range(0, 32767);
    return $urandom_range(1500, 12000);
  endfunction

  task automatic send_random_item();
    int unsigned roll;
    int unsigned v;
    logic [6:0]  note;
    roll = $urandom_range(0, 99);
    note = 7'($urandom_range(0, 127));
    if (roll < 35) begin
      send_item(OP_NOTE_ON, note, 7'($urandom_range(0, 127)));
    end else if (roll < 60) begin
      // Mostly release a note that is held, so that voices reach release and idle.
      v = $urandom_range(0, NV - 1);
      if ($urandom_range(0, 4) != 0 && v_active[v]) note = v_note[v];
      send_item(OP_NOTE_OFF, note, 7'($urandom_range(0, 127)));
    end else if (roll < 95) begin
      send_item(OP_TICK, note, 7'($urandom_range(0, 127)));
    end else begin
      send_item(OP_IGNORED, note, 7'($urandom_range(0, 127)));
    end
  endtask

  // Reset state, filling the pool, voice stealing and note-off matching, all at
  // the reset register values.
  task automatic test_voice_pool();
    send_item(OP_TICK, 7'd0, 7'd0);
    send_item(OP_NOTE_OFF, 7'd60, 7'd0);
    send_item(OP_IGNORED, 7'd127, 7'd127);
    send_item(OP_NOTE_ON, 7'd0, 7'd0);
    send_item(OP_NOTE_ON, 7'd127, 7'd127);
    send_item(OP_NOTE_ON, 7'd69, 7'd100);
    send_item(OP_NOTE_ON, 7'd11, 7'd1);
    send_item(OP_NOTE_ON, 7'd60, 7'd64);
    send_item(OP_NOTE_ON, 7'd119, 7'd85);
    send_item(OP_NOTE_ON, 7'd120, 7'd42);
    send_item(OP_NOTE_ON, 7'd64, 7'd21);
    // The pool is full now, so this one takes over the oldest voice.
    send_item(OP_NOTE_ON, 7'd72, 7'd99);
    send_item(OP_NOTE_OFF, 7'd127, 7'd0);
    // A voice in release is still active and matches again.
    send_item(OP_NOTE_OFF, 7'd127, 7'd127);
    send_item(OP_TICK, 7'd127, 7'd127);
    send_item(OP_NOTE_ON, 7'd50, 7'd77);
    send_item(OP_TICK, 7'd0, 7'd0);
    drain();
  endtask

  // Extreme steps: a full attack step saturates at once, a full release step
  // empties at once, and zero steps freeze a level in attack or release.
  task automatic test_envelope_extremes();
    configure(32767, 32767, 31);
    send_item(OP_TICK, 7'd0, 7'd0);
    send_item(OP_NOTE_OFF, 7'd69, 7'd0);
    send_item(OP_TICK, 7'd0, 7'd0);
    send_item(OP_NOTE_ON, 7'd5, 7'd5);
    send_item(OP_TICK, 7'd0, 7'd0);
    drain();
    configure(0, 0, 0);
    send_item(OP_NOTE_ON, 7'd33, 7'd33);
    send_item(OP_TICK, 7'd0, 7'd0);
    send_item(OP_NOTE_OFF, 7'd33, 7'd0);
    send_item(OP_NOTE_OFF, 7'd119, 7'd0);
    send_item(OP_TICK, 7'd0, 7'd0);
    drain();
  endtask

  // Random traffic in three phases, each with its own register setting; the
  // middle phase runs without idling on either side.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      configure(random_env_step(), random_env_step(), $urandom_range(0, 31));
      quiet = (phase == 1);
      repeat (25) send_random_item();
      drain();
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so that the output register fills and the input stream stalls.
  task automatic test_backpressure();
    configure(4096, 2048, 2);
    quiet = 1'b1;
    hold_requests++;
    repeat (3) send_item(OP_TICK, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    repeat (4) send_item(OP_NOTE_ON, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    send_item(OP_TICK, 7'd0, 7'd0);
    send_item(OP_NOTE_OFF, v_note[0], 7'd0);
    send_item(OP_TICK, 7'd0, 7'd0);
    drain();
    quiet = 1'b0;
    configure(ATTACK_RESET, RELEASE_RESET, GLIDE_RESET);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_voice_pool();
    test_envelope_extremes();
    test_random_traffic();
    test_backpressure();
    if (reports_due.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", reports_due.size());
    end
    $display("Checked %0d result transactions from %0d input transactions over %0d settings.",
             reports_checked, items_taken, settings_used);
    $display("Saw %0d voice steals, %0d unmatched note-offs and %0d ignored codes.",
             steals, offs_missed, ignored_codes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
